[src/boi_pkg.sv]
// ----------------------------------------------------------------------------
// boi_pkg: shared types and constants of the bind opcode interpreter
// Opcode codes, parse phases, register indexes and the command record that
// passes from the parser to the executor.
// ----------------------------------------------------------------------------
package boi_pkg;

  localparam int DEF_SEGMENTS   = 6;
  localparam int DEF_MAX_REPEAT = 64;
  localparam int NUM_BASES      = 6;
  localparam int REP_W          = 7;
  localparam int QUEUE_DEPTH    = 4;
  localparam int MAX_LEB_BYTES  = 10;

  localparam logic [3:0] OP_DONE          = 4'h0;
  localparam logic [3:0] OP_ORD_IMM       = 4'h1;
  localparam logic [3:0] OP_ORD_ULEB      = 4'h2;
  localparam logic [3:0] OP_ORD_SPECIAL   = 4'h3;
  localparam logic [3:0] OP_SET_SYM       = 4'h4;
  localparam logic [3:0] OP_SET_TYPE      = 4'h5;
  localparam logic [3:0] OP_SET_ADDEND    = 4'h6;
  localparam logic [3:0] OP_SET_SEG       = 4'h7;
  localparam logic [3:0] OP_ADD_ADDR      = 4'h8;
  localparam logic [3:0] OP_BIND          = 4'h9;
  localparam logic [3:0] OP_BIND_ADD_ULEB = 4'hA;
  localparam logic [3:0] OP_BIND_ADD_IMM  = 4'hB;
  localparam logic [3:0] OP_REPEAT        = 4'hC;

  localparam logic [2:0] CFG_LAZY     = 3'd0;
  localparam logic [2:0] CFG_SEGCOUNT = 3'd1;
  localparam logic [2:0] CFG_BASE0    = 3'd2;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_ULEB,
    PH_SLEB,
    PH_NAME,
    PH_ULEB2
  } phase_t;

  typedef enum logic [1:0] {
    K_SETOFF,
    K_ADDOFF,
    K_BIND,
    K_RUN
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              clr;
    logic              ok;
    logic              clamped;
    logic [REP_W-1:0]  iters;
    logic [3:0]        seg;
    logic [15:0]       sym;
    logic [63:0]       value;
  } cmd_t;

endpackage

[src/boi_front.sv]
// ----------------------------------------------------------------------------
// boi_front: byte parser
// Decodes opcodes and LEB128 operands, keeps segment, symbol and halt state,
// and issues offset and bind commands to the queue.
// ----------------------------------------------------------------------------
module boi_front import boi_pkg::*; #(
  parameter int SEGMENTS   = DEF_SEGMENTS,
  parameter int MAX_REPEAT = DEF_MAX_REPEAT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  input  logic        lazy_mode,
  input  logic [2:0]  segment_count,
  output logic        push,
  output cmd_t        cmd
);

  phase_t      phase, phase_step, phase_next;
  logic [3:0]  pop, pop_step;
  logic [63:0] acc, acc_step;
  logic [3:0]  cnt, cnt_step;
  logic [63:0] hold, hold_step;
  logic [3:0]  seg, seg_step;
  logic        name, name_step;
  logic [15:0] sym, sym_step;
  logic        halted, halt_step;
  logic        push_any;

  logic [3:0]  op, imm, cnt_inc;
  logic [6:0]  shamt;
  logic [63:0] acc_or;
  logic        leb_end;
  logic [2:0]  limit;
  logic        bind_ok;

  assign op      = stream_byte[7:4];
  assign imm     = stream_byte[3:0];
  assign cnt_inc = cnt + 4'd1;
  assign shamt   = 7'(cnt) * 7'd7;
  assign acc_or  = acc | ({57'd0, stream_byte[6:0]} << shamt);
  assign leb_end = !stream_byte[7] || (cnt_inc >= 4'(MAX_LEB_BYTES));
  assign limit   = (32'(segment_count) < SEGMENTS) ? segment_count : 3'(SEGMENTS);
  assign bind_ok = name && (seg < {1'b0, limit});

  function automatic cmd_t make_run(input logic [63:0] count, input logic [63:0] skip,
                                    input logic ok_i, input logic [3:0] seg_i,
                                    input logic [15:0] sym_i);
    cmd_t c;
    c         = '0;
    c.kind    = K_RUN;
    c.ok      = ok_i;
    c.seg     = seg_i;
    c.sym     = sym_i;
    c.value   = skip + 64'd8;
    c.clamped = count > 64'(MAX_REPEAT);
    c.iters   = c.clamped ? REP_W'(MAX_REPEAT) : REP_W'(count);
    return c;
  endfunction

  // next state
  always_comb begin
    phase_step = phase;
    if (!halted) begin
      case (phase)
        PH_OPCODE: begin
          case (op)
            OP_ORD_ULEB, OP_ADD_ADDR, OP_REPEAT, OP_SET_SEG, OP_BIND_ADD_ULEB:
              phase_step = PH_ULEB;
            OP_SET_SYM:    phase_step = PH_NAME;
            OP_SET_ADDEND: phase_step = PH_SLEB;
            default:       phase_step = PH_OPCODE;
          endcase
        end
        PH_NAME:  if (stream_byte == 8'd0) phase_step = PH_OPCODE;
        PH_SLEB:  if (leb_end) phase_step = PH_OPCODE;
        PH_ULEB:  if (leb_end) phase_step = (pop == OP_REPEAT) ? PH_ULEB2 : PH_OPCODE;
        PH_ULEB2: if (leb_end) phase_step = PH_OPCODE;
        default:  phase_step = PH_OPCODE;
      endcase
    end
    phase_next = end_of_stream ? PH_OPCODE : phase_step;
  end

  // datapath and commands
  always_comb begin
    pop_step  = pop;
    acc_step  = acc;
    cnt_step  = cnt;
    hold_step = hold;
    seg_step  = seg;
    name_step = name;
    sym_step  = sym;
    halt_step = halted;
    push_any  = 1'b0;
    cmd       = '0;
    cmd.ok    = bind_ok;
    cmd.seg   = seg;
    cmd.sym   = sym - 16'd1;
    if (!halted) begin
      case (phase)
        PH_OPCODE: begin
          pop_step = op;
          case (op)
            OP_DONE: if (!lazy_mode) halt_step = 1'b1;
            OP_ORD_IMM, OP_ORD_SPECIAL, OP_SET_TYPE: ;
            OP_ORD_ULEB, OP_ADD_ADDR, OP_SET_ADDEND, OP_REPEAT: begin
              acc_step = '0;
              cnt_step = '0;
            end
            OP_SET_SYM: begin
              sym_step  = sym + 16'd1;
              name_step = 1'b0;
            end
            OP_SET_SEG: begin
              seg_step = imm;
              acc_step = '0;
              cnt_step = '0;
            end
            OP_BIND: begin
              push_any  = 1'b1;
              cmd.kind  = K_BIND;
              cmd.value = 64'd8;
            end
            OP_BIND_ADD_ULEB: begin
              push_any  = 1'b1;
              cmd.kind  = K_BIND;
              cmd.value = 64'd8;
              acc_step  = '0;
              cnt_step  = '0;
            end
            OP_BIND_ADD_IMM: begin
              push_any  = 1'b1;
              cmd.kind  = K_BIND;
              cmd.value = 64'd8 + {57'd0, imm, 3'd0};
            end
            default: halt_step = 1'b1;
          endcase
        end
        PH_NAME: if (stream_byte != 8'd0) name_step = 1'b1;
        PH_SLEB: cnt_step = cnt_inc;
        PH_ULEB, PH_ULEB2: begin
          acc_step = acc_or;
          cnt_step = cnt_inc;
          if (leb_end) begin
            if (pop == OP_REPEAT) begin
              if (phase == PH_ULEB) begin
                hold_step = acc_or;
                acc_step  = '0;
                cnt_step  = '0;
              end else begin
                push_any = 1'b1;
                cmd      = make_run(hold, acc_or, bind_ok, seg, sym - 16'd1);
              end
            end else if (pop == OP_SET_SEG) begin
              push_any  = 1'b1;
              cmd.kind  = K_SETOFF;
              cmd.value = acc_or;
            end else if (pop == OP_ADD_ADDR || pop == OP_BIND_ADD_ULEB) begin
              push_any  = 1'b1;
              cmd.kind  = K_ADDOFF;
              cmd.value = acc_or;
            end
          end
        end
        default: ;
      endcase
      // finish a repeat run cut short by the end of the stream
      if (end_of_stream && !halt_step && pop_step == OP_REPEAT) begin
        if (phase_step == PH_ULEB) begin
          push_any = 1'b1;
          cmd      = make_run(acc_step, 64'd0, bind_ok, seg, sym - 16'd1);
        end else if (phase_step == PH_ULEB2) begin
          push_any = 1'b1;
          cmd      = make_run(hold_step, acc_step, bind_ok, seg, sym - 16'd1);
        end
      end
    end
    if (end_of_stream) begin
      if (!push_any) begin
        cmd.kind  = K_SETOFF;
        cmd.value = '0;
      end
      push_any = 1'b1;
      cmd.clr  = 1'b1;
    end
  end

  assign push = accept && push_any;

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_stream)) begin
      phase  <= PH_OPCODE;
      pop    <= '0;
      acc    <= '0;
      cnt    <= '0;
      hold   <= '0;
      seg    <= '0;
      name   <= 1'b0;
      sym    <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      pop    <= pop_step;
      acc    <= acc_step;
      cnt    <= cnt_step;
      hold   <= hold_step;
      seg    <= seg_step;
      name   <= name_step;
      sym    <= sym_step;
      halted <= halt_step;
    end
  end

endmodule

[src/boi_queue.sv]
// ----------------------------------------------------------------------------
// boi_queue: command queue
// Small first-in first-out buffer between the parser and the executor.
// ----------------------------------------------------------------------------
module boi_queue import boi_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr, rd;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd];

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + PW'(1);
      if (pop)  rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[src/boi_back.sv]
// ----------------------------------------------------------------------------
// boi_back: command executor
// Keeps the segment offset, walks repeat runs one bind a cycle when the output
// register is free, and holds each result beat in the output register.
// ----------------------------------------------------------------------------
module boi_back import boi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  cmd_t        head,
  output logic        pop,
  input  logic [63:0] bases [NUM_BASES],
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] bind_address,
  output logic [15:0] symbol_number,
  output logic        repeat_clamped,
  output logic        last_of_run
);

  logic [63:0]      offset, offset_next;
  logic [REP_W-1:0] it, it_next;
  logic             slot_free, emit, last;
  logic [63:0]      base_sel;

  assign slot_free = !out_valid || out_ready;
  assign base_sel  = (32'(head.seg) < NUM_BASES) ? bases[head.seg[2:0]] : '0;

  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    last        = 1'b0;
    offset_next = offset;
    it_next     = it;
    if (nonempty && slot_free) begin
      case (head.kind)
        K_SETOFF: begin
          offset_next = head.value;
          pop         = 1'b1;
        end
        K_ADDOFF: begin
          offset_next = offset + head.value;
          pop         = 1'b1;
        end
        K_BIND: begin
          emit        = head.ok;
          last        = 1'b1;
          offset_next = offset + head.value;
          pop         = 1'b1;
        end
        K_RUN: begin
          if (head.iters == '0) begin
            pop = 1'b1;
          end else begin
            emit        = head.ok;
            offset_next = offset + head.value;
            if (it == head.iters - REP_W'(1)) begin
              pop     = 1'b1;
              last    = 1'b1;
              it_next = '0;
            end else begin
              it_next = it + REP_W'(1);
            end
          end
        end
        default: pop = 1'b1;
      endcase
      if (pop && head.clr) offset_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      it        <= '0;
      out_valid <= 1'b0;
    end else begin
      offset <= offset_next;
      it     <= it_next;
      if (slot_free) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      bind_address   <= base_sel + offset;
      symbol_number  <= head.sym;
      repeat_clamped <= head.clamped;
      last_of_run    <= last;
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
      (nonempty && head.kind == K_RUN && head.iters != '0) |-> it < head.iters)
    else $error("run iteration beyond count");
  a_iter_idle: assert property (@(posedge clk) disable iff (rst)
      (nonempty && head.kind != K_RUN) |-> it == '0)
    else $error("iteration count left over");
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
      emit |-> slot_free)
    else $error("beat produced into a full output register");

endmodule

[src/bind_opcode_interpreter.sv]
// ----------------------------------------------------------------------------
// bind_opcode_interpreter: bind opcode stream decoder
// Each result beat is registered in the command queue and then in the output
// register after the byte that causes it. Throughput: 1 byte per cycle; the
// executor walks repeat runs bind by bind; a full queue stalls the input.
// Reset clears parse state, offset, queue and configuration registers.
// ----------------------------------------------------------------------------
module bind_opcode_interpreter import boi_pkg::*; #(
  parameter int SEGMENTS   = DEF_SEGMENTS,
  parameter int MAX_REPEAT = DEF_MAX_REPEAT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] bind_address,
  output logic [15:0] symbol_number,
  output logic        repeat_clamped,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        lazy_mode;
  logic [2:0]  segment_count;
  logic [63:0] bases [NUM_BASES];
  logic        accept, push, full, nonempty, pop;
  cmd_t        cmd, head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lazy_mode     <= 1'b0;
      segment_count <= '0;
      for (int i = 0; i < NUM_BASES; i++) bases[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LAZY)     lazy_mode     <= cfg_data[0];
      if (cfg_index == CFG_SEGCOUNT) segment_count <= cfg_data[2:0];
      for (int i = 0; i < NUM_BASES; i++) begin
        if (cfg_index == CFG_BASE0 + 3'(i)) bases[i] <= cfg_data;
      end
    end
  end

  boi_front #(
    .SEGMENTS   (SEGMENTS),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .stream_byte   (stream_byte),
    .end_of_stream (end_of_stream),
    .lazy_mode     (lazy_mode),
    .segment_count (segment_count),
    .push          (push),
    .cmd           (cmd)
  );

  boi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  boi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .nonempty       (nonempty),
    .head           (head),
    .pop            (pop),
    .bases          (bases),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bind_address   (bind_address),
    .symbol_number  (symbol_number),
    .repeat_clamped (repeat_clamped),
    .last_of_run    (last_of_run)
  );

endmodule

[test/bind_opcode_interpreter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bind_opcode_interpreter_test: self-checking bench for the bind opcode decoder
// Feeds directed and randomly built bind opcode streams through the byte
// channel, predicts every bind beat in a behavioural model of the decoder and
// compares each output beat field by field. Sender idling and receiver stalls
// change from phase to phase, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module bind_opcode_interpreter_test;
  import boi_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_beat_t;

  typedef struct {
    logic [63:0] addr;
    logic [15:0] sym;
    logic        clamped;
    logic        last;
  } bind_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] bind_address;
  logic [15:0] symbol_number;
  logic        repeat_clamped;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  bind_opcode_interpreter dut (.*);

  stream_beat_t byte_q[$];
  bind_beat_t   bind_q[$];
  int           fails;
  int           idle_pct;
  int           stall_pct;
  bit           eos_next_name;

  // register mirror
  logic        lazy_r;
  logic [2:0]  segcnt_r;
  logic [63:0] base_r[NUM_BASES];

  // decoder state mirror
  phase_t      phase_s;
  logic [3:0]  pend_op;
  logic [63:0] acc;
  int          acc_cnt;
  logic [63:0] count_hold;
  logic [3:0]  seg_s;
  logic [63:0] offset_s;
  logic        named;
  logic [15:0] sym_cnt;
  logic        halted;

  bind_beat_t  step_binds[$];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_decoder();
    phase_s    = PH_OPCODE;
    pend_op    = OP_DONE;
    acc        = '0;
    acc_cnt    = 0;
    count_hold = '0;
    seg_s      = '0;
    offset_s   = '0;
    named      = 0;
    sym_cnt    = '0;
    halted     = 0;
  endfunction

  function automatic void bind_slot(logic clamped);
    int lim;
    bind_beat_t b;
    lim = (segcnt_r < DEF_SEGMENTS) ? segcnt_r : DEF_SEGMENTS;
    if (!named || seg_s >= lim) return;
    b.addr    = base_r[seg_s] + offset_s;
    b.sym     = sym_cnt - 16'd1;
    b.clamped = clamped;
    b.last    = 0;
    step_binds.insert(step_binds.size(), b);
  endfunction

  function automatic void run_repeat(logic [63:0] count, logic [63:0] skip);
    logic  clamped;
    longint iters;
    clamped = count > DEF_MAX_REPEAT;
    iters   = clamped ? DEF_MAX_REPEAT : count;
    for (longint i = 0; i < iters; i++) begin
      bind_slot(clamped);
      offset_s += 64'd8 + skip;
    end
  endfunction

  function automatic void open_uleb(phase_t p);
    phase_s = p;
    acc     = '0;
    acc_cnt = 0;
  endfunction

  function automatic void decode_opcode(logic [7:0] b);
    logic [3:0] op;
    logic [3:0] imm;
    op = b[7:4];
    imm = b[3:0];
    pend_op = op;
    case (op)
      OP_DONE: if (!lazy_r) halted = 1;
      OP_ORD_IMM, OP_ORD_SPECIAL, OP_SET_TYPE: ;
      OP_ORD_ULEB, OP_ADD_ADDR, OP_REPEAT: open_uleb(PH_ULEB);
      OP_SET_SYM: begin
        sym_cnt = sym_cnt + 16'd1;
        named   = 0;
        phase_s = PH_NAME;
      end
      OP_SET_ADDEND: open_uleb(PH_SLEB);
      OP_SET_SEG: begin
        seg_s = imm;
        open_uleb(PH_ULEB);
      end
      OP_BIND: begin
        bind_slot(0);
        offset_s += 64'd8;
      end
      OP_BIND_ADD_ULEB: begin
        bind_slot(0);
        offset_s += 64'd8;
        open_uleb(PH_ULEB);
      end
      OP_BIND_ADD_IMM: begin
        bind_slot(0);
        offset_s += 64'd8 + 64'(imm) * 64'd8;
      end
      default: halted = 1;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eos);
    logic [63:0] v;
    step_binds.delete();
    if (!halted) begin
      case (phase_s)
        PH_OPCODE: decode_opcode(b);
        PH_NAME: begin
          if (b == 8'h00) phase_s = PH_OPCODE;
          else named = 1;
        end
        PH_SLEB: begin
          acc_cnt++;
          if (!b[7] || acc_cnt >= MAX_LEB_BYTES) phase_s = PH_OPCODE;
        end
        PH_ULEB, PH_ULEB2: begin
          acc |= 64'(b[6:0]) << (7 * acc_cnt);
          acc_cnt++;
          if (!b[7] || acc_cnt >= MAX_LEB_BYTES) begin
            v = acc;
            if (pend_op == OP_REPEAT) begin
              if (phase_s == PH_ULEB) begin
                count_hold = v;
                open_uleb(PH_ULEB2);
              end else begin
                phase_s = PH_OPCODE;
                run_repeat(count_hold, v);
              end
            end else begin
              phase_s = PH_OPCODE;
              if (pend_op == OP_SET_SEG) offset_s = v;
              else if (pend_op == OP_ADD_ADDR || pend_op == OP_BIND_ADD_ULEB) offset_s += v;
            end
          end
        end
        default: phase_s = PH_OPCODE;
      endcase
      if (eos && !halted && pend_op == OP_REPEAT) begin
        if (phase_s == PH_ULEB) run_repeat(acc, 64'd0);
        else if (phase_s == PH_ULEB2) run_repeat(count_hold, acc);
      end
    end
    if (step_binds.size() > 0) step_binds[step_binds.size() - 1].last = 1;
    foreach (step_binds[i]) bind_q.insert(bind_q.size(), step_binds[i]);
    if (eos) clear_decoder();
  endfunction

  // ---- stream building ----
  function automatic void put(logic [7:0] b, logic eos);
    stream_beat_t s;
    s.data = b;
    s.eos  = eos;
    byte_q.insert(byte_q.size(), s);
    if (eos) eos_next_name = 1;
  endfunction

  function automatic void put_r(logic [7:0] b);
    put(b, $urandom_range(99) < 3);
  endfunction

  function automatic void put_uleb(logic [63:0] v);
    logic [7:0] b;
    if ($urandom_range(15) == 0) begin
      for (int i = 0; i < MAX_LEB_BYTES; i++) put_r(8'h80 | 8'($urandom_range(127)));
      return;
    end
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1;
      put_r(b);
    end while (v != 0);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return $urandom_range(300);
      2: return {$urandom, $urandom};
      default: return $urandom_range(4096);
    endcase
  endfunction

  function automatic void put_name();
    int len;
    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
    put_r(8'h40 | 8'($urandom_range(15)));
    for (int i = 0; i < len; i++) put_r(8'($urandom_range(1, 255)));
    put_r(8'h00);
  endfunction

  function automatic void put_record();
    int r;
    if (eos_next_name) begin
      eos_next_name = 0;
      put_name();
      return;
    end
    r = $urandom_range(99);
    if (r < 8) put_name();
    else if (r < 18) begin
      put_r(8'h70 | 8'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(5)));
      put_uleb(rand_value());
    end
    else if (r < 33) put_r(8'h90 | 8'($urandom_range(15)));
    else if (r < 43) put_r(8'hB0 | 8'($urandom_range(15)));
    else if (r < 53) begin
      put_r(8'hA0 | 8'($urandom_range(15)));
      put_uleb(rand_value());
    end
    else if (r < 66) begin
      put_r(8'hC0 | 8'($urandom_range(15)));
      put_uleb(($urandom_range(7) == 0) ? rand_value() : $urandom_range(70));
      put_uleb(rand_value());
    end
    else if (r < 72) begin
      put_r(8'h80 | 8'($urandom_range(15)));
      put_uleb(rand_value());
    end
    else if (r < 78) begin
      case ($urandom_range(3))
        0: put_r(8'h10 | 8'($urandom_range(15)));
        1: put_r(8'h30 | 8'($urandom_range(15)));
        2: put_r(8'h50 | 8'($urandom_range(15)));
        default: begin
          put_r(8'h20 | 8'($urandom_range(15)));
          put_uleb(rand_value());
        end
      endcase
    end
    else if (r < 84) begin
      put_r(8'h60 | 8'($urandom_range(15)));
      repeat ($urandom_range(0, 10)) put_r(8'h80 | 8'($urandom_range(127)));
      put_r(8'($urandom_range(127)));
    end
    else if (r < 87) put_r(8'h00 | 8'($urandom_range(15)));
    else if (r < 89) put_r(8'($urandom_range(8'hD0, 8'hFF)));
    else put_r(8'($urandom_range(255)));
  endfunction

  function automatic void fill_stream(int n);
    int start;
    start = byte_q.size();
    while (byte_q.size() - start < n) put_record();
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    stream_beat_t s;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) predict_byte(stream_byte, end_of_stream);
      if (!in_valid || in_ready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s = byte_q.pop_front();
          in_valid      <= 1;
          stream_byte   <= s.data;
          end_of_stream <= s.eos;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    bind_beat_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= $urandom_range(99) >= stall_pct;
      if (out_valid && out_ready) begin
        if (bind_q.size() == 0) begin
          $error("unexpected bind beat: address %h", bind_address);
          fails++;
        end else begin
          e = bind_q.pop_front();
          if (bind_address !== e.addr) begin
            $error("bind_address expected %h actual %h", e.addr, bind_address);
            fails++;
          end
          if (symbol_number !== e.sym) begin
            $error("symbol_number expected %0d actual %0d", e.sym, symbol_number);
            fails++;
          end
          if (repeat_clamped !== e.clamped) begin
            $error("repeat_clamped expected %b actual %b", e.clamped, repeat_clamped);
            fails++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, last_of_run);
            fails++;
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
    if (idx == CFG_LAZY) lazy_r = data[0];
    else if (idx == CFG_SEGCOUNT) segcnt_r = data[2:0];
    else base_r[idx - CFG_BASE0] = data;
  endtask

  task automatic drain();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || bind_q.size() != 0);
  endtask

  task automatic program_regs(logic lazy, logic [2:0] cnt, int base_kind);
    logic [63:0] b;
    cfg_write(CFG_LAZY, 64'(lazy));
    cfg_write(CFG_SEGCOUNT, 64'(cnt));
    for (int i = 0; i < NUM_BASES; i++) begin
      case (base_kind)
        0: b = '0;
        1: b = '1;
        default: b = {$urandom, $urandom};
      endcase
      cfg_write(CFG_BASE0 + 3'(i), b);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    stream_byte = '0;
    end_of_stream = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    fails = 0;
    idle_pct = 0;
    stall_pct = 0;
    eos_next_name = 0;
    lazy_r = 0;
    segcnt_r = '0;
    foreach (base_r[i]) base_r[i] = '0;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed stream: all opcodes, clamp, empty name, bad segment, halt
    program_regs(0, 3'd6, 1);
    put(8'h40, 0); put(8'h5F, 0); put(8'h00, 0);
    put(8'h72, 0); put(8'hFF, 0); put(8'h7F, 0);
    put(8'h90, 0); put(8'hBF, 0); put(8'hA0, 0); put(8'h10, 0);
    put(8'hC0, 0); put(8'h46, 0); put(8'h01, 0);
    put(8'h60, 0); put(8'hFF, 0); put(8'h7F, 0);
    put(8'h13, 0); put(8'h20, 0); put(8'h05, 0); put(8'h30, 0); put(8'h51, 0);
    put(8'h80, 0); put(8'h08, 0);
    put(8'h40, 0); put(8'h00, 0); put(8'h90, 0);
    put(8'h00, 0); put(8'h90, 0); put(8'hFF, 1);
    drain();
    repeat (10) @(posedge clk);
    program_regs(1, 3'd2, 0);
    put(8'h41, 0); put(8'h61, 0); put(8'h00, 0);
    put(8'h76, 0); put(8'h00, 0); put(8'h90, 0);
    put(8'h71, 0); put(8'h00, 0); put(8'h00, 0); put(8'h90, 0);
    put(8'hD0, 0); put(8'h90, 0); put(8'h00, 1);
    put(8'h40, 0); put(8'h41, 0); put(8'h00, 0);
    put(8'hC0, 0); put(8'h83, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      repeat (10) @(posedge clk);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  program_regs(0, 3'd6, 2); end
        1: begin idle_pct = 56; stall_pct = 0;  program_regs(1, 3'd0, 2); end
        2: begin idle_pct = 0;  stall_pct = 56; program_regs(1, 3'd6, 1); end
        default: begin idle_pct = 31; stall_pct = 31; program_regs(0, 3'd3, 2); end
      endcase
      eos_next_name = 1;
      if (ph == 2) begin
        fill_stream(28);
        drain();
        fill_stream(28);
      end else begin
        fill_stream(56);
      end
      put(8'($urandom_range(255)), 1);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
